// ===== rtl/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg: shared definitions for the line pixel generator
// Coordinate width default, color width and request operation codes.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS_DEFAULT = 10;
    localparam int COLOR_BITS         = 32;

    // Request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

endpackage

// ===== rtl/line_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// line_pixel_generator: exact line rasterizer, one pixel per step request
// Remainder accumulator walks the major axis; no division.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_ready): operation selects load or step.
//   A load request latches two endpoints and a color, swaps the axes when
//   the line is steep and orders the endpoints along the major axis. A load
//   produces no pixel and replaces any line still in progress.
//   A step request while a line is active produces one pixel on the pixel
//   channel (pix_valid / pix_ready); last_pixel marks the final one. A step
//   while idle is accepted and dropped.
//   A pixel is valid in the cycle after its step request is accepted.
//   Throughput: one request per cycle. The per-step work is one add and one
//   compare on the remainder accumulator, done between the line state
//   registers and the pixel output register.
//   Stall: the pixel output register is the only buffer. While it holds a
//   pixel that is not taken, req_ready is low; it rises in the same cycle
//   that pix_ready takes the pixel, so requests keep flowing back to back.
//   Reset (rst_n low, asynchronous): no line is active, no pixel is valid.
// ----------------------------------------------------------------------------
module line_pixel_generator #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic                           operation,
    input  logic [COORD_BITS-1:0]          start_x,
    input  logic [COORD_BITS-1:0]          start_y,
    input  logic [COORD_BITS-1:0]          end_x,
    input  logic [COORD_BITS-1:0]          end_y,
    input  logic [lpg_pkg::COLOR_BITS-1:0] draw_color,
    // pixel channel
    output logic                           pix_valid,
    input  logic                           pix_ready,
    output logic [COORD_BITS-1:0]          pixel_x,
    output logic [COORD_BITS-1:0]          pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                           last_pixel
);

    // ---------------- line state ----------------
    logic                           active_reg,       active_next;
    logic                           steep_reg,        steep_next;
    logic [COORD_BITS-1:0]          major_pos_reg,    major_pos_next;
    logic [COORD_BITS-1:0]          major_end_reg,    major_end_next;
    logic [COORD_BITS-1:0]          minor_base_reg,   minor_base_next;
    logic [COORD_BITS-1:0]          minor_offset_reg, minor_offset_next;
    logic [COORD_BITS:0]            remainder_reg,    remainder_next;
    logic [COORD_BITS-1:0]          major_span_reg,   major_span_next;
    logic [COORD_BITS-1:0]          minor_span_reg,   minor_span_next;
    logic                           minor_down_reg,   minor_down_next;
    logic [lpg_pkg::COLOR_BITS-1:0] color_reg,        color_next;

    // ---------------- pixel output register ----------------
    logic                           pix_valid_reg, pix_valid_next;
    logic [COORD_BITS-1:0]          pix_x_reg,     pix_x_next;
    logic [COORD_BITS-1:0]          pix_y_reg,     pix_y_next;
    logic [lpg_pkg::COLOR_BITS-1:0] pix_color_reg;
    logic                           pix_last_reg,  pix_last_next;

    logic req_fire;
    logic is_load;
    logic emit;

    // load-side geometry
    logic [COORD_BITS-1:0] dx_abs, dy_abs;
    logic                  steep_in;
    logic [COORD_BITS-1:0] a1, b1, a2, b2;
    logic                  swap_ends;
    logic [COORD_BITS-1:0] lo_major, hi_major, lo_minor, hi_minor;

    // step-side arithmetic
    logic [COORD_BITS-1:0] minor_now;
    logic                  at_end;
    logic [COORD_BITS:0]   rem_sum;

    // Accept whenever the output register is free or being emptied now.
    assign req_ready = !pix_valid_reg || pix_ready;
    assign req_fire  = req_valid && req_ready;
    assign is_load   = (operation == lpg_pkg::OP_LOAD);
    assign emit      = req_fire && !is_load && active_reg;

    // Steep test and endpoint ordering on the incoming endpoints.
    always_comb
    begin
        dx_abs    = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
        dy_abs    = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
        steep_in  = (dx_abs < dy_abs);
        a1        = steep_in ? start_y : start_x;
        b1        = steep_in ? start_x : start_y;
        a2        = steep_in ? end_y   : end_x;
        b2        = steep_in ? end_x   : end_y;
        // equal major coordinates keep their order
        swap_ends = (a1 > a2);
        lo_major  = swap_ends ? a2 : a1;
        hi_major  = swap_ends ? a1 : a2;
        lo_minor  = swap_ends ? b2 : b1;
        hi_minor  = swap_ends ? b1 : b2;
    end

    // Current pixel: a falling minor axis rounds the offset up.
    always_comb
    begin
        if (minor_down_reg)
        begin
            minor_now = minor_base_reg - minor_offset_reg
                      - {{(COORD_BITS-1){1'b0}}, (remainder_reg != '0)};
        end
        else
        begin
            minor_now = minor_base_reg + minor_offset_reg;
        end
        at_end  = (major_pos_reg == major_end_reg);
        rem_sum = remainder_reg + {1'b0, minor_span_reg};
    end

    // Next line state.
    always_comb
    begin
        active_next       = active_reg;
        steep_next        = steep_reg;
        major_pos_next    = major_pos_reg;
        major_end_next    = major_end_reg;
        minor_base_next   = minor_base_reg;
        minor_offset_next = minor_offset_reg;
        remainder_next    = remainder_reg;
        major_span_next   = major_span_reg;
        minor_span_next   = minor_span_reg;
        minor_down_next   = minor_down_reg;
        color_next        = color_reg;

        if (req_fire && is_load)
        begin
            active_next       = 1'b1;
            steep_next        = steep_in;
            major_pos_next    = lo_major;
            major_end_next    = hi_major;
            minor_base_next   = lo_minor;
            minor_offset_next = '0;
            remainder_next    = '0;
            major_span_next   = hi_major - lo_major;
            minor_span_next   = (lo_minor > hi_minor) ? (lo_minor - hi_minor)
                                                      : (hi_minor - lo_minor);
            minor_down_next   = (hi_minor < lo_minor);
            color_next        = draw_color;
        end
        else if (emit)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
                if (rem_sum >= {1'b0, major_span_reg})
                begin
                    remainder_next    = rem_sum - {1'b0, major_span_reg};
                    minor_offset_next = minor_offset_reg + 1'b1;
                end
                else
                begin
                    remainder_next = rem_sum;
                end
            end
        end
    end

    // Next output register contents.
    always_comb
    begin
        pix_x_next     = steep_reg ? minor_now : major_pos_reg;
        pix_y_next     = steep_reg ? major_pos_reg : minor_now;
        pix_last_next  = at_end;
        if (emit)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_ready)
        begin
            pix_valid_next = 1'b0;
        end
        else
        begin
            pix_valid_next = pix_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            steep_reg        <= 1'b0;
            major_pos_reg    <= '0;
            major_end_reg    <= '0;
            minor_base_reg   <= '0;
            minor_offset_reg <= '0;
            remainder_reg    <= '0;
            major_span_reg   <= '0;
            minor_span_reg   <= '0;
            minor_down_reg   <= 1'b0;
            color_reg        <= '0;
            pix_valid_reg    <= 1'b0;
        end
        else
        begin
            active_reg       <= active_next;
            steep_reg        <= steep_next;
            major_pos_reg    <= major_pos_next;
            major_end_reg    <= major_end_next;
            minor_base_reg   <= minor_base_next;
            minor_offset_reg <= minor_offset_next;
            remainder_reg    <= remainder_next;
            major_span_reg   <= major_span_next;
            minor_span_reg   <= minor_span_next;
            minor_down_reg   <= minor_down_next;
            color_reg        <= color_next;
            pix_valid_reg    <= pix_valid_next;
        end
    end

    // Pixel payload: load only when a new pixel is produced.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_x_reg     <= pix_x_next;
            pix_y_reg     <= pix_y_next;
            pix_color_reg <= color_reg;
            pix_last_reg  <= pix_last_next;
        end
    end

    assign pix_valid   = pix_valid_reg;
    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign pixel_color = pix_color_reg;
    assign last_pixel  = pix_last_reg;

endmodule

// ===== rtl/lpg_checker.sv =====
// ----------------------------------------------------------------------------
// lpg_checker: port-level checks for the line pixel generator
// Watches the request and pixel channels; bound to the top level below.
// ----------------------------------------------------------------------------
module lpg_checker #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           operation,
    input logic [COORD_BITS-1:0]          start_x,
    input logic [COORD_BITS-1:0]          start_y,
    input logic [COORD_BITS-1:0]          end_x,
    input logic [COORD_BITS-1:0]          end_y,
    input logic [lpg_pkg::COLOR_BITS-1:0] draw_color,
    input logic                           pix_valid,
    input logic                           pix_ready,
    input logic [COORD_BITS-1:0]          pixel_x,
    input logic [COORD_BITS-1:0]          pixel_y,
    input logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    input logic                           last_pixel
);

    logic load_fire;
    logic step_fire;
    logic point_line;

    assign load_fire  = req_valid && req_ready && (operation == lpg_pkg::OP_LOAD);
    assign step_fire  = req_valid && req_ready && (operation == lpg_pkg::OP_STEP);
    assign point_line = (start_x == end_x) && (start_y == end_y);

    // A stalled pixel holds its contents.
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_color) && $stable(last_pixel))
        else $error("stalled pixel changed");

    // A stalled pixel blocks new requests.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |-> !req_ready)
        else $error("request accepted over a stalled pixel");

    // A load never produces a pixel.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> pix_valid == $past(pix_valid && !pix_ready))
        else $error("load produced a pixel");

    // A single-point line gives one final pixel at that point.
    a_point_line: assert property (@(posedge clk) disable iff (!rst_n)
        (load_fire && point_line) ##1 step_fire |=> pix_valid && last_pixel
            && (pixel_x == $past(start_x, 2)) && (pixel_y == $past(start_y, 2))
            && (pixel_color == $past(draw_color, 2)))
        else $error("single-point line pixel wrong");

endmodule

bind line_pixel_generator lpg_checker #(.COORD_BITS(COORD_BITS)) u_lpg_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for line_pixel_generator
// Drives load and step requests with random gaps and output back-pressure,
// keeps a cycle-free model of the rasterizer that predicts every pixel, and
// compares each pixel taken from the block against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB           = lpg_pkg::COORD_BITS_DEFAULT;
    localparam int RANDOM_ITEMS = 1900;

    typedef logic [CB-1:0]                  coord_t;
    typedef logic [lpg_pkg::COLOR_BITS-1:0] color_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    // ------------------------------------------------------------------------
    // Rasterizer model and pixel scoreboard.
    // accept_request() advances the model for every accepted request and
    // queues the pixel a step request should produce; check_pixel() pops the
    // oldest queued pixel and compares it with what came out.
    // ------------------------------------------------------------------------
    class raster_checker;
        bit     drawing;
        bit     swapped;        // major axis is y
        bit     falling;        // minor coordinate decreases along the line
        coord_t major_at;
        coord_t major_stop;
        coord_t minor_origin;
        coord_t minor_steps;    // whole minor steps taken so far
        coord_t major_len;
        coord_t minor_len;
        logic [CB:0] frac;      // k*minor_len mod major_len
        color_t color_hold;
        pixel_t expected_pixels[$];
        int     errors;

        function new();
            drawing      = 1'b0;
            swapped      = 1'b0;
            falling      = 1'b0;
            major_at     = '0;
            major_stop   = '0;
            minor_origin = '0;
            minor_steps  = '0;
            major_len    = '0;
            minor_len    = '0;
            frac         = '0;
            color_hold   = '0;
            errors       = 0;
        endfunction

        static function coord_t span_of(coord_t a, coord_t b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void accept_request(logic op, coord_t sx, coord_t sy, coord_t ex,
                                     coord_t ey, color_t color);
            coord_t a1, b1, a2, b2, t;
            coord_t minor;
            pixel_t px;
            if (op == lpg_pkg::OP_LOAD)
            begin
                // swap axes for steep lines, then order along the major axis
                swapped = span_of(sx, ex) < span_of(sy, ey);
                if (swapped)
                begin
                    a1 = sy; b1 = sx; a2 = ey; b2 = ex;
                end
                else
                begin
                    a1 = sx; b1 = sy; a2 = ex; b2 = ey;
                end
                if (a1 > a2)
                begin
                    t = a1; a1 = a2; a2 = t;
                    t = b1; b1 = b2; b2 = t;
                end
                drawing      = 1'b1;
                major_at     = a1;
                major_stop   = a2;
                minor_origin = b1;
                minor_steps  = '0;
                frac         = '0;
                major_len    = a2 - a1;
                minor_len    = span_of(b1, b2);
                falling      = b2 < b1;
                color_hold   = color;
            end
            else if (drawing)
            begin
                // floor on a rising minor, ceil on a falling one
                if (falling)
                    minor = minor_origin - minor_steps - coord_t'(frac != 0);
                else
                    minor = minor_origin + minor_steps;
                px.x     = swapped ? minor : major_at;
                px.y     = swapped ? major_at : minor;
                px.color = color_hold;
                px.last  = (major_at == major_stop);
                expected_pixels.push_back(px);
                if (px.last)
                begin
                    drawing = 1'b0;
                end
                else
                begin
                    major_at = major_at + 1'b1;
                    frac     = frac + minor_len;
                    if (frac >= major_len)
                    begin
                        frac        = frac - major_len;
                        minor_steps = minor_steps + 1'b1;
                    end
                end
            end
        endfunction

        function void check_pixel(coord_t x, coord_t y, color_t color, logic last);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                $error("pixel (%0d,%0d) taken with no pixel expected", x, y);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (x !== want.x)
                begin
                    $error("pixel_x: expected %0d, got %0d", want.x, x);
                    errors++;
                end
                if (y !== want.y)
                begin
                    $error("pixel_y: expected %0d, got %0d", want.y, y);
                    errors++;
                end
                if (color !== want.color)
                begin
                    $error("pixel_color: expected %h, got %h", want.color, color);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last_pixel: expected %0b, got %0b", want.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   req_valid  = 1'b0;
    logic   req_ready;
    logic   operation  = lpg_pkg::OP_LOAD;
    coord_t start_x    = '0;
    coord_t start_y    = '0;
    coord_t end_x      = '0;
    coord_t end_y      = '0;
    color_t draw_color = '0;
    logic   pix_valid;
    logic   pix_ready  = 1'b0;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;

    raster_checker sb;

    // idle percentages for the request sender and the pixel receiver
    int send_idle = 29;
    int recv_idle = 73;
    int requests_sent = 0;

    line_pixel_generator #(
        .COORD_BITS (CB)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .operation   (operation),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .draw_color  (draw_color),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the pipeline locks up.
    initial
    begin
        #5_000_000;
        $display("line_pixel_generator: mismatch");
        $finish;
    end

    // Back-pressure: drop pix_ready at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        pix_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Handshake monitor. Values seen here are the ones from before the edge,
    // since both the bench and the block update through nonblocking writes.
    // A pixel taken at this edge always belongs to an earlier request, so the
    // order of the two calls does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
                sb.check_pixel(pixel_x, pixel_y, pixel_color, last_pixel);
            if (req_valid && req_ready)
                sb.accept_request(operation, start_x, start_y, end_x, end_y, draw_color);
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: hold valid and payload until the request is taken,
    // with a random number of idle cycles before it.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic op, input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey, input color_t color);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        operation  <= op;
        start_x    <= sx;
        start_y    <= sy;
        end_x      <= ex;
        end_y      <= ey;
        draw_color <= color;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
        requests_sent++;
    endtask

    // Step requests carry junk in the coordinate and color fields; the block
    // must ignore it.
    task automatic step_line(input int count);
        repeat (count)
            send_request(lpg_pkg::OP_STEP, coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom), $urandom);
    endtask

    task automatic draw_line(input coord_t sx, input coord_t sy, input coord_t ex,
                             input coord_t ey, input color_t color, input int steps);
        send_request(lpg_pkg::OP_LOAD, sx, sy, ex, ey, color);
        step_line(steps);
    endtask

    // Coordinate biased toward the edges of the range.
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Coordinate within a short distance of c, clamped to the range.
    function automatic coord_t near(coord_t c);
        int v;
        v = int'(c) + int'($urandom_range(0, 30)) - 15;
        if (v < 0)
            v = 0;
        if (v > (1 << CB) - 1)
            v = (1 << CB) - 1;
        return coord_t'(v);
    endfunction

    // One random line: mostly short lines walked to the end (sometimes with a
    // trailing step while idle), some abandoned part way by the next load,
    // and now and then a line between two random points anywhere in the range.
    task automatic random_line();
        coord_t sx, sy, ex, ey;
        int     span;
        int     steps;
        bit     finish;
        if ($urandom_range(0, 99) < 8)
        begin
            sx = coord_t'($urandom);
            sy = coord_t'($urandom);
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
        end
        else
        begin
            sx = pick_coord();
            sy = pick_coord();
            ex = near(sx);
            ey = near(sy);
        end
        span = int'(raster_checker::span_of(sx, ex));
        if (int'(raster_checker::span_of(sy, ey)) > span)
            span = int'(raster_checker::span_of(sy, ey));
        if (span <= 40)
            finish = ($urandom_range(0, 3) != 0);
        else
            finish = ($urandom_range(0, 11) == 0);
        if (finish)
            steps = span + 1 + ($urandom_range(0, 4) == 0 ? 1 : 0);
        else
            steps = $urandom_range(0, span < 20 ? span : 20);
        draw_line(sx, sy, ex, ey, $urandom, steps);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        int directed_count;
        sb = new();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no line loaded: nothing comes out
        step_line(1);
        // zero-length line: one pixel marked last, then a step while idle
        draw_line(5, 5, 5, 5, 32'h1234_5678, 2);
        // full-range falling diagonal, abandoned by the next load
        draw_line('1, '0, '0, '1, 32'hFFFF_FFFF, 3);
        // flat line on the top row, walked to the end plus one idle step
        draw_line('0, '1, 3, '1, 32'h0000_0000, 5);
        // steep line given end first, abandoned after a few pixels
        draw_line(2, '1, '0, '0, 32'hA5A5_5A5A, 3);
        // shallow line given in reverse order with a falling minor
        draw_line(10, 3, 7, 5, 32'h5A5A_A5A5, 4);
        directed_count = requests_sent;

        // phase 0: sender idles little, receiver stalls a lot
        // phase 1: the other way round
        // phase 2: full rate on both sides
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 29;
                    recv_idle = 73;
                end
                1:
                begin
                    send_idle = 73;
                    recv_idle = 29;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            while (requests_sent < directed_count + RANDOM_ITEMS * (phase + 1) / 3)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(logic'($urandom_range(0, 1)), coord_t'($urandom),
                                 coord_t'($urandom), coord_t'($urandom),
                                 coord_t'($urandom), $urandom);
                else
                    random_line();
            end
        end
        req_valid <= 1'b0;

        // drain outstanding pixels, then give the block a few cycles to
        // show any stray output
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("line_pixel_generator: match");
        else
            $display("line_pixel_generator: mismatch");
        $finish;
    end

endmodule
